FILE: rtl/bmc_pkg.sv
// Package: shared types and constants for the button menu blink-code controller.
`timescale 1ns / 1ps

package bmc_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned OptW  = 2;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_PRESS   = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_UNUSED  = 2'd3
  } req_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HEARTBEAT_HALF = 3'd0,
    REG_ENTER_HOLD     = 3'd1,
    REG_CONFIRM_HOLD   = 3'd2,
    REG_IDLE_TIMEOUT   = 3'd3,
    REG_FLASH_HALF     = 3'd4,
    REG_FLASH_GAP      = 3'd5,
    REG_SPARE6         = 3'd6,
    REG_SPARE7         = 3'd7
  } reg_idx_t;

  localparam logic [CfgW-1:0] HeartbeatHalfRst = 16'd250;
  localparam logic [CfgW-1:0] EnterHoldRst     = 16'd1000;
  localparam logic [CfgW-1:0] ConfirmHoldRst   = 16'd2000;
  localparam logic [CfgW-1:0] IdleTimeoutRst   = 16'd10000;
  localparam logic [CfgW-1:0] FlashHalfRst     = 16'd250;
  localparam logic [CfgW-1:0] FlashGapRst      = 16'd500;

  localparam logic [OptW-1:0] FirstOption = 2'd1;

  typedef struct packed {
    logic            led_on;
    logic            in_menu;
    logic [OptW-1:0] option_shown;
    logic            commit;
    logic [OptW-1:0] commit_option;
  } result_t;

endpackage

FILE: rtl/button_menu_blink_code_controller.sv
// Top level: single-button menu controller with blink-code status LED.
// Path: an accepted word is held in the input register, and its result word is then
// loaded into the output register once that register is empty or being read.
// Throughput: one word per cycle while results are read; the registers decouple the
// channels, so a word is taken while a result waits if the input register is empty.
// Reset (rst, synchronous, active high): heartbeat mode, LED off, option 1, registers
// back to their default millisecond values, both register stages empty.
`timescale 1ns / 1ps

module button_menu_blink_code_controller #(
  parameter int unsigned OPTION_COUNT = 3
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration write port
  input  logic                         cfg_we,
  input  logic [bmc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [bmc_pkg::CfgW-1:0]     cfg_data,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   req_type,
  input  logic [bmc_pkg::TimeW-1:0]    time_ms,
  input  logic [bmc_pkg::TimeW-1:0]    hold_ms,
  // output channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         led_on,
  output logic                         in_menu,
  output logic [bmc_pkg::OptW-1:0]     option_shown,
  output logic                         commit,
  output logic [bmc_pkg::OptW-1:0]     commit_option
);

  import bmc_pkg::*;

  localparam logic [OptW-1:0] LastOption = OptW'(OPTION_COUNT);

  // configuration registers
  logic [CfgW-1:0] heartbeat_half, enter_hold, confirm_hold;
  logic [CfgW-1:0] idle_timeout, flash_half, flash_gap;

  // controller state
  logic             menu_mode, menu_mode_next;
  logic [TimeW-1:0] next_change, next_change_next;
  logic [TimeW-1:0] last_activity, last_activity_next;
  logic [OptW-1:0]  sel_option, sel_option_next;
  logic [OptW-1:0]  flash_count, flash_count_next;
  logic             led_state, led_state_next;

  // input register stage
  logic             s1_valid;
  req_t             s1_req;
  logic [TimeW-1:0] s1_time, s1_hold;
  logic             s1_adv;

  // output register
  result_t          res, res_next;

  // ---------------------------------------------------------------------------
  // Handshake: stage 1 drains into the output register whenever that register
  // is empty or being read; stage 1 refills when empty or draining.
  // ---------------------------------------------------------------------------
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      heartbeat_half <= HeartbeatHalfRst;
      enter_hold     <= EnterHoldRst;
      confirm_hold   <= ConfirmHoldRst;
      idle_timeout   <= IdleTimeoutRst;
      flash_half     <= FlashHalfRst;
      flash_gap      <= FlashGapRst;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_HEARTBEAT_HALF: heartbeat_half <= cfg_data;
        REG_ENTER_HOLD:     enter_hold     <= cfg_data;
        REG_CONFIRM_HOLD:   confirm_hold   <= cfg_data;
        REG_IDLE_TIMEOUT:   idle_timeout   <= cfg_data;
        REG_FLASH_HALF:     flash_half     <= cfg_data;
        REG_FLASH_GAP:      flash_gap      <= cfg_data;
        default: ;  // indexes beyond the register list are dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req  <= req_t'(req_type);
      s1_time <= time_ms;
      s1_hold <= hold_ms;
    end
  end

  // ---------------------------------------------------------------------------
  // Single-pass update. All deadline checks use wrapping 32-bit differences:
  // a deadline is reached when now - target has its sign bit clear.
  // ---------------------------------------------------------------------------
  logic [TimeW-1:0] since_change, since_activity;
  logic             reached;
  logic             idle_expired;
  logic             hold_enter, hold_confirm;
  logic [OptW:0]    flash_inc;
  logic             group_done;

  assign since_change   = s1_time - next_change;
  assign since_activity = s1_time - last_activity;
  assign reached        = !since_change[TimeW-1];
  assign idle_expired   = since_activity >= {{(TimeW-CfgW){1'b0}}, idle_timeout};
  assign hold_enter     = s1_hold >= {{(TimeW-CfgW){1'b0}}, enter_hold};
  assign hold_confirm   = s1_hold >= {{(TimeW-CfgW){1'b0}}, confirm_hold};
  assign flash_inc      = {1'b0, flash_count} + (OptW+1)'(1);
  assign group_done     = flash_inc >= {1'b0, sel_option};

  always_comb begin
    menu_mode_next     = menu_mode;
    next_change_next   = next_change;
    last_activity_next = last_activity;
    sel_option_next    = sel_option;
    flash_count_next   = flash_count;
    led_state_next     = led_state;
    res_next.commit        = 1'b0;
    res_next.commit_option = '0;

    case (s1_req)
      REQ_TICK: begin
        if (!menu_mode) begin
          if (reached) begin
            led_state_next   = !led_state;
            next_change_next = s1_time + {{(TimeW-CfgW){1'b0}}, heartbeat_half};
          end
        end else if (idle_expired) begin
          // menu idle too long: back to heartbeat
          menu_mode_next   = 1'b0;
          led_state_next   = 1'b0;
          next_change_next = s1_time + {{(TimeW-CfgW){1'b0}}, heartbeat_half};
        end else if (reached) begin
          if (!led_state) begin
            led_state_next   = 1'b1;
            next_change_next = s1_time + {{(TimeW-CfgW){1'b0}}, flash_half};
          end else begin
            led_state_next = 1'b0;
            if (group_done) begin
              flash_count_next = '0;
              next_change_next = s1_time + {{(TimeW-CfgW){1'b0}}, flash_gap};
            end else begin
              flash_count_next = flash_inc[OptW-1:0];
              next_change_next = s1_time + {{(TimeW-CfgW){1'b0}}, flash_half};
            end
          end
        end
      end
      REQ_PRESS, REQ_RELEASE: begin
        if (!menu_mode) begin
          if (s1_req == REQ_RELEASE && hold_enter) begin
            menu_mode_next     = 1'b1;
            last_activity_next = s1_time;
            sel_option_next    = FirstOption;
            flash_count_next   = '0;
            led_state_next     = 1'b0;
            next_change_next   = s1_time;
          end
        end else begin
          last_activity_next = s1_time;
          if (s1_req == REQ_RELEASE) begin
            // commit check wins over the short-press check
            if (hold_confirm) begin
              res_next.commit        = 1'b1;
              res_next.commit_option = sel_option;
              menu_mode_next   = 1'b0;
              led_state_next   = 1'b0;
              next_change_next = s1_time + {{(TimeW-CfgW){1'b0}}, heartbeat_half};
            end else if (!hold_enter) begin
              sel_option_next  = (sel_option >= LastOption) ? FirstOption
                                                            : sel_option + OptW'(1);
              flash_count_next = '0;
              led_state_next   = 1'b0;
              next_change_next = s1_time;
            end
          end
        end
      end
      default: ;  // unused request code: state unchanged
    endcase

    res_next.led_on       = led_state_next;
    res_next.in_menu      = menu_mode_next;
    res_next.option_shown = sel_option_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      menu_mode     <= 1'b0;
      next_change   <= '0;
      last_activity <= '0;
      sel_option    <= FirstOption;
      flash_count   <= '0;
      led_state     <= 1'b0;
    end else if (s1_adv) begin
      menu_mode     <= menu_mode_next;
      next_change   <= next_change_next;
      last_activity <= last_activity_next;
      sel_option    <= sel_option_next;
      flash_count   <= flash_count_next;
      led_state     <= led_state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res <= res_next;
    end
  end

  assign led_on        = res.led_on;
  assign in_menu       = res.in_menu;
  assign option_shown  = res.option_shown;
  assign commit        = res.commit;
  assign commit_option = res.commit_option;

`ifndef ASSERT_OFF
  // a commit always lands in heartbeat mode
  a_commit_leaves_menu: assert property (@(posedge clk) disable iff (rst)
    out_valid && commit |-> !in_menu)
    else $error("commit word still shows menu mode");

  // committed option reads zero unless a commit happened
  a_commit_opt_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !commit |-> commit_option == '0)
    else $error("commit_option nonzero without commit");

  // selected option stays within 1..OPTION_COUNT
  a_option_range: assert property (@(posedge clk) disable iff (rst)
    sel_option != '0 && sel_option <= LastOption)
    else $error("selected option out of range");

  // flash count never reaches the selected option
  a_flash_count: assert property (@(posedge clk) disable iff (rst)
    flash_count < sel_option)
    else $error("flash count overran option");
`endif

endmodule
